### rtl/adpu_pkg.sv
// ----------------------------------------------------------------------------
// adpu_pkg: shared types and constants for the AArch64 data-processing unit
// Holds instruction class codes, field constants and the decode record.
// ----------------------------------------------------------------------------
`default_nettype none

package adpu_pkg;

    localparam int unsigned NUM_REGS   = 31;
    localparam int unsigned REG_W      = 64;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] IMM_FIXED  = 3'b100;
    localparam logic [2:0] REG_FIXED  = 3'b101;
    localparam logic [2:0] OPI_ADDSUB = 3'b010;
    localparam logic [2:0] OPI_MOVW   = 3'b101;
    localparam logic [4:0] ZERO_REG   = 5'b11111;

    typedef enum logic [3:0] {
        OP_ADDSUB,
        OP_MOVN,
        OP_MOVZ,
        OP_MOVK,
        OP_LOGIC,
        OP_MADD,
        OP_BAD
    } t_op;

    // Decoded instruction passed from front to back.
    typedef struct packed {
        t_op         op;
        logic        sf;
        logic [1:0]  opc;
        logic [4:0]  rd;
        logic [4:0]  rn;      // first source (movk: rd)
        logic [4:0]  rm;
        logic [4:0]  ra;
        logic        use_imm; // second operand is immediate
        logic [63:0] imm;     // add immediate or wide-move operand
        logic [5:0]  shamt;
        logic [1:0]  shtype;
        logic        negb;    // logic: invert b; madd: subtract
        logic [63:0] keep;    // movk mask of bits kept
    } t_dec;

endpackage

`default_nettype wire

### rtl/adpu_decode.sv
// ----------------------------------------------------------------------------
// adpu_decode: instruction classifier
// Purely combinational decode of one instruction word into a t_dec record.
// ----------------------------------------------------------------------------
`default_nettype none

module adpu_decode
    import adpu_pkg::*;
(
    input  wire logic        i_func,
    input  wire logic [31:0] i_iw,
    output t_dec             o_dec
);

    logic [1:0] hw;
    logic [63:0] wide;

    always_comb begin
        hw   = i_iw[22:21];
        wide = 64'(i_iw[20:5]) << {hw, 4'b0000};
        o_dec         = '0;
        o_dec.op      = OP_BAD;
        o_dec.sf      = i_iw[31];
        o_dec.opc     = i_iw[30:29];
        o_dec.rd      = i_iw[4:0];
        o_dec.rn      = i_iw[9:5];
        o_dec.rm      = i_iw[20:16];
        o_dec.ra      = i_iw[14:10];
        o_dec.shamt   = i_iw[15:10];
        o_dec.shtype  = i_iw[23:22];
        o_dec.imm     = wide;
        o_dec.keep    = ~(64'hFFFF << {hw, 4'b0000});
        if (!i_func) begin
            if (i_iw[28:26] == IMM_FIXED) begin
                if (i_iw[25:23] == OPI_ADDSUB) begin
                    o_dec.op      = OP_ADDSUB;
                    o_dec.use_imm = 1'b1;
                    o_dec.shamt   = '0;
                    o_dec.imm     = i_iw[22] ? 64'(i_iw[21:10]) << 12 : 64'(i_iw[21:10]);
                end else if (i_iw[25:23] == OPI_MOVW) begin
                    if (!(i_iw[30:29] == 2'b01 || (!i_iw[31] && hw[1]))) begin
                        case (i_iw[30:29])
                            2'b00:   o_dec.op = OP_MOVN;
                            2'b10:   o_dec.op = OP_MOVZ;
                            default: o_dec.op = OP_MOVK;
                        endcase
                        o_dec.rn = i_iw[4:0];
                    end
                end
            end
        end else if (i_iw[27:25] == REG_FIXED) begin
            if (i_iw[28]) begin
                if (i_iw[24:21] == 4'b1000 && i_iw[30:29] == 2'b00) begin
                    o_dec.op   = OP_MADD;
                    o_dec.negb = i_iw[15];
                end
            end else if (!(!i_iw[31] && i_iw[15])) begin
                if (!i_iw[24]) begin
                    o_dec.op   = OP_LOGIC;
                    o_dec.negb = i_iw[21];
                end else if (!i_iw[21] && i_iw[23:22] != 2'b11) begin
                    o_dec.op = OP_ADDSUB;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/adpu_queue.sv
// ----------------------------------------------------------------------------
// adpu_queue: decoupling queue
// Small register FIFO of decoded transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module adpu_queue
    import adpu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_dec      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_dec      o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_dec             r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/adpu_execute.sv
// ----------------------------------------------------------------------------
// adpu_execute: execution back end
// Register file, flags, shifter, adder, logic unit and multiplier; retires one
// transaction per cycle into an output register unless stalled or multiplying.
// ----------------------------------------------------------------------------
`default_nettype none

module adpu_execute
    import adpu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  t_dec             i_dec,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic             o_wrote_reg,
    output logic [4:0]       o_dest_index,
    output logic [63:0]      o_dest_value,
    output logic [3:0]       o_flags_nzcv
);

    logic [63:0] r_regs [NUM_REGS];
    logic [3:0]  r_flags;
    logic        r_ovalid;
    logic        r_status, r_wrote;
    logic [4:0]  r_idx;
    logic [63:0] r_val;
    logic [2:0]  r_mstep;   // multiply slices accumulated so far
    logic [63:0] r_prod;

    logic [63:0] m, a, rmv, rav, b, sh, res, prod, sum;
    logic [64:0] addw;
    logic [5:0]  top;
    logic [3:0]  n_flags;
    logic        c, v, ok, fire, n;
    logic        is_mul, mul_done;
    logic [15:0] chunk;
    logic [79:0] pp;
    logic [63:0] pp_sh;

    function automatic logic [63:0] rd_reg(input logic [4:0] idx, input logic [63:0] mask,
                                           input logic [63:0] regs [NUM_REGS]);
        rd_reg = (idx == ZERO_REG) ? 64'd0 : (regs[idx] & mask);
    endfunction

    // multiply: one 16-bit slice of the second operand per cycle
    assign is_mul   = i_valid && (i_dec.op == OP_MADD);
    assign mul_done = (r_mstep == 3'd4);

    assign fire  = i_valid && (!is_mul || mul_done) && (!r_ovalid || !i_stall);
    assign o_pop = fire;

    always_comb begin
        m    = i_dec.sf ? '1 : 64'h0000_0000_FFFF_FFFF;
        top  = i_dec.sf ? 6'd63 : 6'd31;
        a    = rd_reg(i_dec.rn, m, r_regs);
        rmv  = rd_reg(i_dec.rm, m, r_regs);
        rav  = rd_reg(i_dec.ra, m, r_regs);
        // shifter
        sh = rmv;
        if (i_dec.shamt != '0) begin
            case (i_dec.shtype)
                2'b00: sh = (rmv << i_dec.shamt) & m;
                2'b01: sh = rmv >> i_dec.shamt;
                2'b10: sh = i_dec.sf ? 64'($signed(rmv) >>> i_dec.shamt)
                                     : {32'd0, 32'($signed(rmv[31:0]) >>> i_dec.shamt)};
                default: sh = i_dec.sf ? ((rmv >> i_dec.shamt) | (rmv << (7'd64 - 7'(i_dec.shamt))))
                                       : 64'(32'((rmv[31:0] >> i_dec.shamt)
                                         | (rmv[31:0] << (6'd32 - i_dec.shamt))));
            endcase
        end
        b = i_dec.use_imm ? (i_dec.imm & m) : sh;
        // adder
        if (i_dec.opc[1]) begin
            addw = {1'b0, a} + {1'b0, ~b & m} + 65'd1;
        end else begin
            addw = {1'b0, a} + {1'b0, b};
        end
        sum = addw[63:0] & m;
        c   = i_dec.sf ? addw[64] : addw[32];
        if (i_dec.opc[1]) begin
            v = ((a[top] ^ b[top]) & (a[top] ^ sum[top]));
        end else begin
            v = ((a[top] ^ sum[top]) & (b[top] ^ sum[top]));
        end
        // partial product of the current slice
        chunk = rmv[{r_mstep[1:0], 4'b0000} +: 16];
        pp    = a * chunk;
        pp_sh = pp[63:0] << {r_mstep[1:0], 4'b0000};
        prod  = r_prod;
        n_flags = r_flags;
        ok  = 1'b1;
        res = '0;
        case (i_dec.op)
            OP_ADDSUB: begin
                res = sum;
                if (i_dec.opc[0]) n_flags = {sum[top], sum == '0, c, v};
            end
            OP_MOVN: res = ~i_dec.imm & m;
            OP_MOVZ: res = i_dec.imm & m;
            OP_MOVK: res = ((a & i_dec.keep) | i_dec.imm) & m;
            OP_LOGIC: begin
                n = i_dec.negb;
                case (i_dec.opc)
                    2'b01:   res = a | (n ? ~sh & m : sh);
                    2'b10:   res = a ^ (n ? ~sh & m : sh);
                    default: res = a & (n ? ~sh & m : sh);
                endcase
                if (i_dec.opc == 2'b11) n_flags = {res[top], res == '0, 2'b00};
            end
            OP_MADD: res = (i_dec.negb ? rav - prod : rav + prod) & m;
            default: ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_flags  <= '0;
            r_mstep  <= '0;
            r_prod   <= '0;
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= '0;
        end else begin
            if (fire) begin
                r_ovalid <= 1'b1;
                if (ok) begin
                    r_flags <= n_flags;
                    if (i_dec.rd != ZERO_REG) r_regs[i_dec.rd] <= res;
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (fire) begin
                r_mstep <= '0;
                r_prod  <= '0;
            end else if (is_mul && !mul_done) begin
                r_mstep <= r_mstep + 3'd1;
                r_prod  <= r_prod + pp_sh;
            end
        end
        if (fire) begin
            r_status <= !ok;
            r_wrote  <= ok && (i_dec.rd != ZERO_REG);
            r_idx    <= i_dec.rd;
            r_val    <= res;
        end
    end

    // flags output follows the flags register, updated together with the result
    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_wrote_reg  = r_wrote;
    assign o_dest_index = r_idx;
    assign o_dest_value = r_val;
    assign o_flags_nzcv = r_flags;

endmodule

`default_nettype wire

### rtl/aarch64_data_processing_unit.sv
// ----------------------------------------------------------------------------
// aarch64_data_processing_unit: AArch64 integer data-processing subset
// Executes one instruction word per transaction against X0..X30 and NZCV.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_stall) carries i_func (class) and i_instr_word.
//   Output channel (o_valid/i_stall) returns status, write flag, Rd index,
//   the computed value and the NZCV flags after the instruction.
//   The front decodes each word in the accepting cycle and pushes the
//   decoded record into a two-entry queue. The back reads the register
//   file and executes the queue head, loading the output register from
//   which the result is offered. Throughput is one transaction per cycle
//   when the receiver does not stall and no madd/msub is running; a result
//   updates the register file as it is written to the output register, so
//   the following instruction sees it directly. Madd/msub hold the back
//   while a 64x16 multiplier builds the product one slice per cycle.
//   When the receiver stalls the output register holds, the back stops, the
//   queue fills and o_stall rises once it is full.
//   Synchronous reset clears X0..X30, the flags and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aarch64_data_processing_unit
    import adpu_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_instr_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic             o_wrote_reg,
    output logic [4:0]       o_dest_index,
    output logic [63:0]      o_dest_value,
    output logic [3:0]       o_flags_nzcv
);

    t_dec dec, qdata;
    logic full, qvalid, pop;

    adpu_decode u_dec (
        .i_func (i_func),
        .i_iw   (i_instr_word),
        .o_dec  (dec)
    );

    assign o_stall = full;

    adpu_queue #(.DEPTH(QDEPTH)) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !full),
        .i_data  (dec),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (qdata)
    );

    adpu_execute u_ex (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (qvalid),
        .i_dec        (qdata),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_wrote_reg  (o_wrote_reg),
        .o_dest_index (o_dest_index),
        .o_dest_value (o_dest_value),
        .o_flags_nzcv (o_flags_nzcv)
    );

endmodule

`default_nettype wire

### rtl/adpu_checker.sv
// ----------------------------------------------------------------------------
// adpu_checker: port-level checks
// Watches the top level's ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adpu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_status,
    input wire logic        o_wrote_reg,
    input wire logic [4:0]  o_dest_index,
    input wire logic [63:0] o_dest_value
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_value))
        else $error("stalled result changed");

    a_err_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_wrote_reg && o_dest_value == 64'd0)
        else $error("error result wrote");

    a_zr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dest_index == 5'b11111 |-> !o_wrote_reg)
        else $error("write to zero register");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall after reset");

endmodule

bind aarch64_data_processing_unit adpu_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_wrote_reg  (o_wrote_reg),
    .o_dest_index (o_dest_index),
    .o_dest_value (o_dest_value)
);

`default_nettype wire
